### sv/drpf_pkg.sv
`timescale 1ns / 1ps

package drpf_pkg;

    // Default frame geometry.
    localparam int FRAME_COLUMNS_DEF = 160;
    localparam int FRAME_ROWS_DEF    = 128;

    // Palette geometry is fixed.
    localparam int PALETTE_SIZE = 16;
    localparam int PAL_IDX_W    = $clog2(PALETTE_SIZE);
    localparam int COLOR_W      = 16;

    // The position may run one whole write run past the frame end.
    localparam int RUN_SPAN = 128;

    // Input item commands.
    localparam logic IN_STREAM  = 1'b0;
    localparam logic IN_PALETTE = 1'b1;

    // Stream opcodes.
    localparam logic [7:0] OP_END_MARK = 8'h00;
    localparam int         OP_RUN_BIT  = 7;

    // Display commands and filler bytes.
    localparam logic [7:0] DISP_CASET = 8'h2A;
    localparam logic [7:0] DISP_PASET = 8'h2B;
    localparam logic [7:0] DISP_RAMWR = 8'h2C;
    localparam logic [7:0] DISP_ZERO  = 8'h00;

    // Kind of output sequence that one input item produces.
    typedef enum logic [1:0] {
        KIND_MARK,
        KIND_HEADER,
        KIND_PIXELS
    } t_kind;

    // One pending sequence of output words, handed from decoder to emitter.
    typedef struct packed {
        t_kind              kind;
        logic               two_pix;
        logic               count_zero;
        logic               run_end;
        logic               frame_end;
        logic [COLOR_W-1:0] color0;
        logic [COLOR_W-1:0] color1;
    } t_job;

    // One result word.
    typedef struct packed {
        logic       word_valid;
        logic       is_data;
        logic [7:0] word_byte;
        logic       select_release;
        logic       frame_done;
        logic       last;
    } t_word;

endpackage

### sv/drpf_div.sv
`timescale 1ns / 1ps

// Splits the pixel position into column and row with a reciprocal multiply.
module drpf_div import drpf_pkg::*; #(
    parameter int FRAME_COLUMNS = FRAME_COLUMNS_DEF,
    parameter int FRAME_ROWS    = FRAME_ROWS_DEF
) (
    input  logic                                                   i_clk,
    input  logic [$clog2(FRAME_COLUMNS*FRAME_ROWS+RUN_SPAN)-1:0]   i_pos,
    output logic [7:0]                                             o_x,
    output logic [7:0]                                             o_y
);

    localparam int POS_W = $clog2(FRAME_COLUMNS*FRAME_ROWS + RUN_SPAN);
    localparam int COL_L = $clog2(FRAME_COLUMNS);
    localparam int SHIFT = POS_W + COL_L;
    localparam int PROD_W = 2*POS_W + 1;
    localparam int Q_W   = PROD_W - SHIFT;
    localparam longint unsigned MULT_L =
        ((64'd1 << SHIFT) + FRAME_COLUMNS - 1) / FRAME_COLUMNS;
    localparam logic [POS_W:0] MULT = MULT_L[POS_W:0];

    logic [PROD_W-1:0] w_prod;
    logic [Q_W-1:0]    r_q;
    logic [POS_W-1:0]  w_qc;

    // The rounded-up reciprocal gives the exact quotient for any position
    // that fits in POS_W bits.
    assign w_prod = {{(POS_W+1){1'b0}}, i_pos} * {{POS_W{1'b0}}, MULT};

    always_ff @(posedge i_clk) begin
        r_q <= w_prod[PROD_W-1:SHIFT];
    end

    assign w_qc = POS_W'(r_q * FRAME_COLUMNS);
    assign o_x  = 8'(i_pos - w_qc);
    assign o_y  = 8'(r_q);

endmodule

### sv/drpf_decode.sv
`timescale 1ns / 1ps

// Stream state, palette memory and the pending job register.
module drpf_decode import drpf_pkg::*; #(
    parameter int FRAME_COLUMNS = FRAME_COLUMNS_DEF,
    parameter int FRAME_ROWS    = FRAME_ROWS_DEF
) (
    input  logic                                                 i_clk,
    input  logic                                                 i_rst_n,
    input  logic                                                 i_valid,
    output logic                                                 o_ready,
    input  logic                                                 i_command,
    input  logic [7:0]                                           i_stream_byte,
    input  logic [PAL_IDX_W-1:0]                                 i_palette_index,
    input  logic [COLOR_W-1:0]                                   i_palette_color,
    input  logic                                                 i_job_done,
    output logic                                                 o_job_valid,
    output t_job                                                 o_job,
    output logic [$clog2(FRAME_COLUMNS*FRAME_ROWS+RUN_SPAN)-1:0] o_pos
);

    localparam int FRAME_SIZE = FRAME_COLUMNS * FRAME_ROWS;
    localparam int POS_W = $clog2(FRAME_SIZE + RUN_SPAN);
    localparam logic [POS_W-1:0] FS_P = POS_W'(FRAME_SIZE);

    logic [COLOR_W-1:0] r_pal [PALETTE_SIZE];
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [6:0]         r_left, n_left;
    logic               r_in_run, n_in_run;
    logic               r_job_valid;
    t_job               r_job, n_job;
    logic               n_job_load;

    logic               w_accept;
    logic               w_two;
    logic [1:0]         w_step;
    logic [6:0]         w_left_after;
    logic [POS_W-1:0]   w_pix_pos;
    logic [POS_W-1:0]   w_skip_pos;

    // A new item enters once the pending job has issued its final word.
    assign o_ready  = !r_job_valid || i_job_done;
    assign w_accept = i_valid && o_ready;

    assign w_two        = r_left > 7'd1;
    assign w_step       = w_two ? 2'd2 : 2'd1;
    assign w_left_after = r_left - 7'(w_step);
    assign w_pix_pos    = r_pos + POS_W'(w_step);
    assign w_skip_pos   = r_pos + POS_W'(i_stream_byte);

    always_comb begin
        n_job      = '0;
        n_job_load = 1'b0;
        n_pos      = r_pos;
        n_left     = r_left;
        n_in_run   = r_in_run;
        if (i_command == IN_STREAM) begin
            if (r_in_run) begin
                n_job.kind    = KIND_PIXELS;
                n_job.two_pix = w_two;
                n_job_load    = 1'b1;
                n_left        = w_left_after;
                n_pos         = w_pix_pos;
                if (w_left_after == 7'd0) begin
                    n_in_run      = 1'b0;
                    n_job.run_end = 1'b1;
                    if (w_pix_pos >= FS_P) begin
                        n_job.frame_end = 1'b1;
                        n_pos           = '0;
                    end
                end
            end else if (i_stream_byte == OP_END_MARK) begin
                n_job.kind = KIND_MARK;
                n_job_load = 1'b1;
                n_pos      = '0;
            end else if (!i_stream_byte[OP_RUN_BIT]) begin
                if (w_skip_pos >= FS_P) begin
                    n_job.kind = KIND_MARK;
                    n_job_load = 1'b1;
                    n_pos      = '0;
                end else begin
                    n_pos = w_skip_pos;
                end
            end else begin
                n_job.kind       = KIND_HEADER;
                n_job.count_zero = (i_stream_byte[6:0] == 7'd0);
                n_job_load       = 1'b1;
                n_left           = i_stream_byte[6:0];
                n_in_run         = (i_stream_byte[6:0] != 7'd0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_left      <= '0;
            r_in_run    <= 1'b0;
            r_job_valid <= 1'b0;
        end else if (w_accept) begin
            r_pos       <= n_pos;
            r_left      <= n_left;
            r_in_run    <= n_in_run;
            r_job_valid <= n_job_load;
        end else if (i_job_done) begin
            r_job_valid <= 1'b0;
        end
    end

    // Palette memory with registered reads into the job register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            if (i_command == IN_PALETTE) begin
                r_pal[i_palette_index] <= i_palette_color;
            end else begin
                r_job <= {n_job.kind, n_job.two_pix, n_job.count_zero, n_job.run_end,
                          n_job.frame_end, r_pal[i_stream_byte[7:4]],
                          r_pal[i_stream_byte[3:0]]};
            end
        end
    end

    assign o_job_valid = r_job_valid;
    assign o_job       = r_job;
    assign o_pos       = r_pos;

`ifndef NO_ASSERTIONS
    a_run_has_pixels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_run |-> (r_left != 7'd0))
        else $error("write run open with no pixels left");

    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_run |-> (r_pos < FS_P))
        else $error("position past frame end outside a write run");
`endif

endmodule

### sv/drpf_emit.sv
`timescale 1ns / 1ps

// Walks the pending job into the output register one word per cycle, while that register is empty or i_ready is high.
module drpf_emit import drpf_pkg::*; #(
    parameter int FRAME_COLUMNS = FRAME_COLUMNS_DEF,
    parameter int FRAME_ROWS    = FRAME_ROWS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_job_valid,
    input  t_job       i_job,
    input  logic [7:0] i_x,
    input  logic [7:0] i_y,
    output logic       o_job_done,
    output logic       o_valid,
    input  logic       i_ready,
    output t_word      o_word
);

    localparam logic [3:0] HDR_CASET = 4'd0;
    localparam logic [3:0] HDR_XS_HI = 4'd1;
    localparam logic [3:0] HDR_XS    = 4'd2;
    localparam logic [3:0] HDR_XE_HI = 4'd3;
    localparam logic [3:0] HDR_XE    = 4'd4;
    localparam logic [3:0] HDR_PASET = 4'd5;
    localparam logic [3:0] HDR_YS_HI = 4'd6;
    localparam logic [3:0] HDR_YS    = 4'd7;
    localparam logic [3:0] HDR_YE_HI = 4'd8;
    localparam logic [3:0] HDR_YE    = 4'd9;
    localparam logic [3:0] HDR_RAMWR = 4'd10;
    localparam logic [3:0] PIX_LAST_ONE = 4'd1;
    localparam logic [3:0] PIX_LAST_TWO = 4'd3;

    logic [3:0]         r_idx;
    logic               r_out_valid;
    t_word              r_out;
    t_word              w_word;
    logic               w_load;
    logic [COLOR_W-1:0] w_color;
    logic               w_pix_last;

    assign w_color    = r_idx[1] ? i_job.color1 : i_job.color0;
    assign w_pix_last = i_job.two_pix ? (r_idx == PIX_LAST_TWO) : (r_idx == PIX_LAST_ONE);

    always_comb begin
        w_word = '0;
        case (i_job.kind)
            KIND_MARK: begin
                w_word.frame_done = 1'b1;
                w_word.last       = 1'b1;
            end
            KIND_HEADER: begin
                w_word.word_valid = 1'b1;
                w_word.is_data    = 1'b1;
                case (r_idx)
                    HDR_CASET: begin
                        w_word.is_data   = 1'b0;
                        w_word.word_byte = DISP_CASET;
                    end
                    HDR_XS_HI: w_word.word_byte = DISP_ZERO;
                    HDR_XS:    w_word.word_byte = i_x;
                    HDR_XE_HI: w_word.word_byte = DISP_ZERO;
                    HDR_XE:    w_word.word_byte = 8'(FRAME_COLUMNS - 1);
                    HDR_PASET: begin
                        w_word.is_data   = 1'b0;
                        w_word.word_byte = DISP_PASET;
                    end
                    HDR_YS_HI: w_word.word_byte = DISP_ZERO;
                    HDR_YS:    w_word.word_byte = i_y;
                    HDR_YE_HI: w_word.word_byte = DISP_ZERO;
                    HDR_YE:    w_word.word_byte = 8'(FRAME_ROWS - 1);
                    HDR_RAMWR: begin
                        w_word.is_data        = 1'b0;
                        w_word.word_byte      = DISP_RAMWR;
                        w_word.select_release = i_job.count_zero;
                        w_word.last           = 1'b1;
                    end
                    default: begin
                        w_word.word_byte = DISP_ZERO;
                        w_word.last      = 1'b1;
                    end
                endcase
            end
            KIND_PIXELS: begin
                w_word.word_valid     = 1'b1;
                w_word.is_data        = 1'b1;
                w_word.word_byte      = r_idx[0] ? w_color[7:0] : w_color[15:8];
                w_word.select_release = w_pix_last && i_job.run_end;
                w_word.frame_done     = w_pix_last && i_job.frame_end;
                w_word.last           = w_pix_last;
            end
            default: begin
                w_word.last = 1'b1;
            end
        endcase
    end

    assign w_load     = i_job_valid && (!r_out_valid || i_ready);
    assign o_job_done = w_load && w_word.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
            r_idx       <= w_word.last ? 4'd0 : r_idx + 4'd1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_word;
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

`ifndef NO_ASSERTIONS
    a_idx_needs_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != 4'd0) |-> i_job_valid)
        else $error("word index advanced without a pending job");

    a_mark_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.word_valid) |-> (r_out.frame_done && r_out.last))
        else $error("result without a display word does not end the frame");

    a_release_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.select_release) |-> (r_out.word_valid && r_out.last))
        else $error("select release on a word that is not the final one");
`endif

endmodule

### sv/delta_rle_palette_frame_decoder.sv
`timescale 1ns / 1ps

// Delta run-length palette frame decoder.
// Input channel (i_valid / o_ready): each item is either a stream byte
// (i_command = 0) or a palette load (i_command = 1) of one 16-bit color.
// Output channel (o_valid / i_ready): each item is one result, normally a
// 9-bit display word (o_is_data plus o_word_byte), with o_last marking the
// final result of the input item that caused it.
// An accepted item is first held in the job register; the emitter then
// moves its first result into the output register. Results leave at one
// per cycle while i_ready is high, so a packed pixel byte gives 4 display
// words (2 on the final odd pixel), a run opcode 11 for the window header,
// and an end marker 1 result. The rate is set by the single word-wide
// output register, which the emitter fills once per cycle from a
// one-entry job register, when it is empty or the receiver takes its word.
// Palette loads and silent skips wait for the pending job's final word.
// Column and row for the window header come from a reciprocal multiply
// that finishes well before those header words are due.
// Reset clears the pixel position and the run state; palette entries hold
// no defined value until loaded. When the receiver holds i_ready low, the
// output register holds its word and the input stalls once the job
// register is full; nothing is dropped.
module delta_rle_palette_frame_decoder import drpf_pkg::*; #(
    parameter int FRAME_COLUMNS = FRAME_COLUMNS_DEF,
    parameter int FRAME_ROWS    = FRAME_ROWS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_command,
    input  logic [7:0]           i_stream_byte,
    input  logic [PAL_IDX_W-1:0] i_palette_index,
    input  logic [COLOR_W-1:0]   i_palette_color,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_word_valid,
    output logic                 o_is_data,
    output logic [7:0]           o_word_byte,
    output logic                 o_select_release,
    output logic                 o_frame_done,
    output logic                 o_last
);

    localparam int POS_W = $clog2(FRAME_COLUMNS*FRAME_ROWS + RUN_SPAN);

    logic             w_job_valid;
    logic             w_job_done;
    t_job             w_job;
    logic [POS_W-1:0] w_pos;
    logic [7:0]       w_x;
    logic [7:0]       w_y;
    t_word            w_word;

    // Stream state, palette and the pending job.
    drpf_decode #(
        .FRAME_COLUMNS (FRAME_COLUMNS),
        .FRAME_ROWS    (FRAME_ROWS)
    ) u_decode (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_command       (i_command),
        .i_stream_byte   (i_stream_byte),
        .i_palette_index (i_palette_index),
        .i_palette_color (i_palette_color),
        .i_job_done      (w_job_done),
        .o_job_valid     (w_job_valid),
        .o_job           (w_job),
        .o_pos           (w_pos)
    );

    // The position is stable while a header job is pending, so the split
    // into column and row is ready by the time those words go out.
    drpf_div #(
        .FRAME_COLUMNS (FRAME_COLUMNS),
        .FRAME_ROWS    (FRAME_ROWS)
    ) u_div (
        .i_clk (i_clk),
        .i_pos (w_pos),
        .o_x   (w_x),
        .o_y   (w_y)
    );

    drpf_emit #(
        .FRAME_COLUMNS (FRAME_COLUMNS),
        .FRAME_ROWS    (FRAME_ROWS)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .i_x         (w_x),
        .i_y         (w_y),
        .o_job_done  (w_job_done),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_word      (w_word)
    );

    assign o_word_valid     = w_word.word_valid;
    assign o_is_data        = w_word.is_data;
    assign o_word_byte      = w_word.word_byte;
    assign o_select_release = w_word.select_release;
    assign o_frame_done     = w_word.frame_done;
    assign o_last           = w_word.last;

endmodule
